>>> rtl/bblur_pkg.sv
// Shared types and constants for the 3x3 box blur core.
// Holds the pixel and sum types and the divide-by-nine helper.
// No dependencies.
package bblur_pkg;

  typedef logic [7:0]  chan_t;
  typedef logic [23:0] rgb_t;

  // Sum of one window column: three bytes per channel
  typedef struct packed {
    logic [9:0] r;
    logic [9:0] g;
    logic [9:0] b;
  } colsum_t;

  // Sum of the whole 3x3 window: nine bytes per channel
  typedef struct packed {
    logic [11:0] r;
    logic [11:0] g;
    logic [11:0] b;
  } winsum_t;

  localparam chan_t       ALPHA_OPAQUE = 8'hFF;
  // ceil(2^16 / 9); exact floor for sums up to 9 * 255
  localparam logic [12:0] DIV9_MUL     = 13'd7282;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  function automatic colsum_t col_add(input rgb_t a, input rgb_t b, input rgb_t c);
    colsum_t s;
    s.r = 10'(a[23:16]) + 10'(b[23:16]) + 10'(c[23:16]);
    s.g = 10'(a[15:8])  + 10'(b[15:8])  + 10'(c[15:8]);
    s.b = 10'(a[7:0])   + 10'(b[7:0])   + 10'(c[7:0]);
    return s;
  endfunction

  function automatic chan_t div9(input logic [11:0] s);
    logic [24:0] p;
    p = 25'(s) * 25'(DIV9_MUL);
    return p[23:16];
  endfunction

endpackage

>>> rtl/bblur_ram.sv
// Generic single-write, single-read synchronous RAM.
// Read data is registered and holds while re is low; reads see old data.
// No dependencies.
module bblur_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/box_blur_3x3_rgba_core.sv
// Top level of the streaming 3x3 box blur for RGBA8888 frames.
// Depends on bblur_pkg and two bblur_ram line stores.
//
//   channel  | signals                                    | word
//   ---------+--------------------------------------------+---------------------------
//   input    | in_valid / in_ready                        | action, pixel_in
//   output   | out_valid / out_ready                      | pixel_out, out_col, out_row,
//            |                                            | frame_end
//   config   | psel penable pwrite paddr pwdata prdata    | frame_width, frame_height
//
// One word per clock sustained while the output is not held. A word passes three
// registers (line store read, window sum, divide) on its way to the output. Each
// line store is read once per accepted word and written once per word leaving the
// read stage. Reset clears control state and the window sums; the line stores are
// never cleared. A held output fills the sum and read stages, then in_ready drops.
module box_blur_3x3_rgba_core
  import bblur_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [31:0] pixel_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] pixel_out,
  output logic [9:0]  out_col,
  output logic [9:0]  out_row,
  output logic        frame_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_HEIGHT);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  // configuration
  logic [10:0]   frame_width;
  logic [10:0]   frame_height;
  logic          cfg_wr;
  logic [CW-1:0] w_last;
  logic [HW-1:0] h_last;

  // input position
  logic [CW-1:0] in_col;
  logic [RW-1:0] in_row;

  // accept-side decode
  logic          acc;
  logic          first;
  logic          skip;
  logic          emit;
  logic          fend;
  logic [RW-1:0] row_m1;
  logic [RW-1:0] row_m2;
  logic [RW-1:0] h_ext;
  logic          fwd_hit;

  // read stage
  logic          s1_valid;
  logic          s1_adv;
  logic [CW-1:0] s1_col;
  logic          s1_first;
  logic          s1_has_top;
  logic          s1_has_mid;
  logic          s1_emit;
  logic          s1_fend;
  logic [9:0]    s1_ocol;
  logic [9:0]    s1_orow;
  rgb_t          s1_bot;
  logic          s1_fwd;
  rgb_t          fwd_a;
  rgb_t          fwd_b;
  rgb_t          rd_a;
  rgb_t          rd_b;
  rgb_t          top;
  rgb_t          mid;
  colsum_t       newcol;
  colsum_t       cs1;
  colsum_t       cs2;
  colsum_t       addcol;
  winsum_t       total;

  // sum stage
  logic          s2_valid;
  logic          s2_free;
  winsum_t       s2_sum;
  logic [9:0]    s2_col;
  logic [9:0]    s2_row;
  logic          s2_fend;

  logic          out_adv;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_HEIGHT) ? {21'b0, frame_height} : {21'b0, frame_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 11'd800;
      frame_height <= 11'd600;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH) begin
        frame_width <= pwdata[10:0];
      end else begin
        frame_height <= pwdata[10:0];
      end
    end
  end

  // clamp to 1..MAX, kept as last index
  always_comb begin
    if (frame_width == '0) begin
      w_last = '0;
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(32'(frame_width) - 32'd1);
    end
    if (frame_height == '0) begin
      h_last = '0;
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h_last = HW'(MAX_HEIGHT - 1);
    end else begin
      h_last = HW'(32'(frame_height) - 32'd1);
    end
  end

  // ---------------------------------------------------------------- accept
  assign out_adv  = !out_valid || out_ready;
  assign s2_free  = !s2_valid || out_adv;
  assign s1_adv   = s1_valid && s2_free;
  assign in_ready = !s1_valid || s2_free;
  assign acc      = in_valid && in_ready;

  assign h_ext  = RW'(h_last);
  assign row_m1 = in_row - RW'(1);
  assign row_m2 = in_row - RW'(2);
  assign first  = (in_col == '0);
  // drain with nothing in flight does nothing
  assign skip   = action && first && (in_row == '0);

  // column zero closes the previous row's last pixel two rows up
  always_comb begin
    if (first) begin
      emit = (in_row >= RW'(2)) && (row_m2 <= h_ext);
      fend = (in_row >= RW'(2)) && (row_m2 == h_ext);
    end else begin
      emit = (in_row != '0) && (row_m1 <= h_ext);
      fend = 1'b0;
    end
  end

  // the write leaving the read stage lands after this read: forward it
  assign fwd_hit = s1_adv && (s1_col == in_col);

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      in_col <= '0;
      in_row <= '0;
    end else if (acc && !skip) begin
      if (fend) begin
        in_col <= '0;
        in_row <= '0;
      end else if (in_col == w_last) begin
        in_col <= '0;
        in_row <= in_row + RW'(1);
      end else begin
        in_col <= in_col + CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------- line stores
  bblur_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_store_a (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (s1_bot),
    .re    (acc),
    .raddr (in_col),
    .rdata (rd_a)
  );

  bblur_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_store_b (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (mid),
    .re    (acc),
    .raddr (in_col),
    .rdata (rd_b)
  );

  // ---------------------------------------------------------------- read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= !skip;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_fwd <= 1'b0;
    end else if (acc) begin
      s1_fwd     <= fwd_hit;
      fwd_a      <= s1_bot;
      fwd_b      <= mid;
      s1_col     <= in_col;
      s1_first   <= first;
      s1_has_top <= (in_row >= RW'(2));
      s1_has_mid <= (in_row != '0);
      s1_emit    <= emit;
      s1_fend    <= fend;
      s1_ocol    <= first ? 10'(w_last) : 10'(in_col - CW'(1));
      s1_orow    <= first ? 10'(row_m2) : 10'(row_m1);
      s1_bot     <= (action || in_row > h_ext) ? '0 : pixel_in[31:8];
    end
  end

  always_comb begin
    top    = s1_has_top ? (s1_fwd ? fwd_b : rd_b) : '0;
    mid    = s1_has_mid ? (s1_fwd ? fwd_a : rd_a) : '0;
    newcol = col_add(top, mid, s1_bot);
    // column zero shifts a zero column in for the right edge
    addcol = s1_first ? '0 : newcol;
    total.r = 12'(cs1.r) + 12'(cs2.r) + 12'(addcol.r);
    total.g = 12'(cs1.g) + 12'(cs2.g) + 12'(addcol.g);
    total.b = 12'(cs1.b) + 12'(cs2.b) + 12'(addcol.b);
  end

  // window held as the sums of its two newest columns
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      cs1 <= '0;
      cs2 <= '0;
    end else if (s1_adv) begin
      if (s1_fend) begin
        cs1 <= '0;
        cs2 <= '0;
      end else begin
        cs1 <= s1_first ? '0 : cs2;
        cs2 <= newcol;
      end
    end
  end

  // ---------------------------------------------------------------- sum stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_adv && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_sum  <= total;
      s2_col  <= s1_ocol;
      s2_row  <= s1_orow;
      s2_fend <= s1_fend;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      pixel_out <= {div9(s2_sum.r), div9(s2_sum.g), div9(s2_sum.b), ALPHA_OPAQUE};
      out_col   <= s2_col;
      out_row   <= s2_row;
      frame_end <= s2_fend;
    end
  end

  // ---------------------------------------------------------------- checks
  a_fwd_follows_item: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_fwd |-> $past(s1_valid))
    else $error("forwarded line data without a preceding item");

  a_sum_held: assert property (@(posedge clk) disable iff (rst)
    s2_valid && out_valid && !out_ready |=> s2_valid)
    else $error("sum stage dropped a word under output stall");

  a_window_cleared: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_fend |=> (cs1 == '0) && (cs2 == '0))
    else $error("window not cleared after frame end");

endmodule
